// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle check: cons must hold whenever ante holds
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check: cons must hold in the cycle after ante
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

  // field widths
  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  // defaults for the cache geometry
  localparam int DEF_BUCKETS = 128;
  localparam int DEF_WAYS    = 4;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // stream widths
  localparam int S_TDATA_W = 192;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 264;
  localparam int M_TUSER_W = 3;
  localparam int CFG_W     = 48;

  // commands
  localparam logic [1:0] CMD_MSG     = 2'd0;
  localparam logic [1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [1:0] CMD_REQUEST = 2'd2;

  // configuration register indexes
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  // protocol constants
  localparam logic [10:0]      MIN_LEN     = 11'd28;
  localparam logic [15:0]      PROTO_IPV4  = 16'h0800;
  localparam logic [15:0]      OP_REQUEST  = 16'd1;
  localparam logic [15:0]      OP_REPLY    = 16'd2;
  localparam logic [1:0]       TX_OP_REQ   = 2'd1;
  localparam logic [1:0]       TX_OP_REP   = 2'd2;
  localparam logic [MAC_W-1:0] BCAST_MAC   = {MAC_W{1'b1}};

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_PROTO = 2'd2;

  // what the back end has to do with a request
  typedef enum logic [2:0] {
    K_NOP,
    K_SHORT,
    K_PROTO,
    K_LEARN,
    K_REPLY,
    K_LOOKUP,
    K_REQUEST
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } task_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             tx_valid;
    logic [MAC_W-1:0] tx_dest_mac;
    logic [1:0]       tx_opcode;
    logic [MAC_W-1:0] tx_sender_mac;
    logic [IP_W-1:0]  tx_sender_ip;
    logic [MAC_W-1:0] tx_target_mac;
    logic [IP_W-1:0]  tx_target_ip;
    logic             lookup_hit;
    logic [MAC_W-1:0] lookup_mac;
  } result_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/arp_responder_with_cache.sv
`default_nettype none

// ARP responder with a hashed ARP cache. Each request on the slave stream is a
// received ARP message, a cache lookup or a command to send an ARP request, and
// gives exactly one result on the master stream. Messages shorter than 28 bytes
// or not IPv4 are rejected; ARP requests and replies learn the sender into a
// cache of BUCKETS by WAYS entries (bucket = sender IP modulo BUCKETS), and a
// request for own_ip gives a reply frame. A front end classifies requests and
// computes the bucket, a two-entry queue decouples it from the back end, which
// reads one bucket row and writes it back when learning. Each part takes a new
// request only when done with the last; with BUCKETS not a power of two the
// front end adds a hash pass, one remainder byte per cycle. The request is
// registered at front-end capture, queue, bucket read and result. After reset
// the cache metadata is cleared one bucket per cycle, during which no request
// is accepted; configuration writes are taken at any time.
module arp_responder_with_cache #(
  parameter int BUCKETS = arpc_pkg::DEF_BUCKETS,
  parameter int WAYS    = arpc_pkg::DEF_WAYS
) (
  input  wire                            clk,
  input  wire                            rst,
  // config write port: index 0 own_ip, index 1 own_mac
  input  wire                            wr_en,
  input  wire                            wr_index,
  input  wire [arpc_pkg::CFG_W-1:0]      wr_data,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  // msg_length, protocol_type, opcode, sender_mac, sender_ip, target_ip, query_ip
  input  wire [arpc_pkg::S_TDATA_W-1:0]  s_tdata,
  // command
  input  wire [arpc_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  wire                            m_tready,
  // tx_dest_mac, tx_opcode, tx_sender_mac, tx_sender_ip, tx_target_mac,
  // tx_target_ip, lookup_hit, lookup_mac
  output logic [arpc_pkg::M_TDATA_W-1:0] m_tdata,
  // status, tx_valid
  output logic [arpc_pkg::M_TUSER_W-1:0] m_tuser
);
  import arpc_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int QW = $bits(task_t) + BW;

  logic [IP_W-1:0]  own_ip;
  logic [MAC_W-1:0] own_mac;

  logic             clearing;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  task_t            f_task;
  logic [BW-1:0]    f_bucket;
  logic [QW-1:0]    q_rdata;
  task_t            b_task;
  logic [BW-1:0]    b_bucket;
  result_t          res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_OWN_IP:  own_ip  <= wr_data[IP_W-1:0];
        REG_OWN_MAC: own_mac <= wr_data[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  arpc_front #(
    .BUCKETS (BUCKETS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .own_ip   (own_ip),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_task   (f_task),
    .q_bucket (f_bucket)
  );

  arpc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_task, f_bucket}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign b_task   = q_rdata[QW-1:BW];
  assign b_bucket = q_rdata[BW-1:0];

  arpc_back #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_empty),
    .q_task    (b_task),
    .q_bucket  (b_bucket),
    .q_pop     (q_pop),
    .own_ip    (own_ip),
    .own_mac   (own_mac),
    .clearing  (clearing),
    .res_valid (m_tvalid),
    .res       (res),
    .res_ready (m_tready)
  );

  // pack the result
  assign m_tdata = {5'd0, res.lookup_mac, res.lookup_hit, res.tx_target_ip,
                    res.tx_target_mac, res.tx_sender_ip, res.tx_sender_mac,
                    res.tx_opcode, res.tx_dest_mac};
  assign m_tuser = {res.tx_valid, res.status};

endmodule

`default_nettype wire

// File: rtl/arpc_front.sv
`default_nettype none

`include "assert_macros.svh"

module arpc_front #(
  parameter int BUCKETS = arpc_pkg::DEF_BUCKETS,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire [arpc_pkg::S_TDATA_W-1:0]  s_tdata,
  input  wire [arpc_pkg::S_TUSER_W-1:0]  s_tuser,
  input  wire [arpc_pkg::IP_W-1:0]       own_ip,
  input  wire                            clearing,
  input  wire                            q_full,
  output logic                           q_push,
  output arpc_pkg::task_t                q_task,
  output logic [BW-1:0]                  q_bucket
);
  import arpc_pkg::*;

  localparam int  XW          = BW + 8;
  localparam bit  BUCKET_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  front_state_t state, state_next;

  logic            accept;
  logic [1:0]      command;
  logic [10:0]     msg_length;
  logic [15:0]     protocol_type;
  logic [15:0]     opcode;
  logic [MAC_W-1:0] sender_mac;
  logic [IP_W-1:0] sender_ip;
  logic [IP_W-1:0] target_ip;
  logic [IP_W-1:0] query_ip;
  kind_t           kind_in;
  logic [IP_W-1:0] ip_in;

  task_t           cur;
  logic [IP_W-1:0] hsh;
  logic [BW-1:0]   rem;
  logic [BW-1:0]   rem_step;
  logic [1:0]      cnt;

  // one remainder step: fold in one byte, then reduce below BUCKETS
  function automatic logic [BW-1:0] mod_step(input logic [BW-1:0] r, input logic [7:0] b);
    logic [XW-1:0] x;
    x = {r, b};
    for (int k = 7; k >= 0; k--) begin
      if (x >= (XW'(BUCKETS) << k)) begin
        x = x - (XW'(BUCKETS) << k);
      end
    end
    return x[BW-1:0];
  endfunction

  // unpack the request
  assign command       = s_tuser[1:0];
  assign msg_length    = s_tdata[10:0];
  assign protocol_type = s_tdata[26:11];
  assign opcode        = s_tdata[42:27];
  assign sender_mac    = s_tdata[90:43];
  assign sender_ip     = s_tdata[122:91];
  assign target_ip     = s_tdata[154:123];
  assign query_ip      = s_tdata[186:155];

  // classify
  always_comb begin
    kind_in = K_NOP;
    ip_in   = query_ip;
    case (command)
      CMD_MSG: begin
        ip_in = sender_ip;
        if (msg_length < MIN_LEN) begin
          kind_in = K_SHORT;
        end else if (protocol_type != PROTO_IPV4) begin
          kind_in = K_PROTO;
        end else if (opcode == OP_REQUEST) begin
          kind_in = (target_ip == own_ip) ? K_REPLY : K_LEARN;
        end else if (opcode == OP_REPLY) begin
          kind_in = K_LEARN;
        end else begin
          kind_in = K_NOP;
        end
      end
      CMD_LOOKUP:  kind_in = K_LOOKUP;
      CMD_REQUEST: kind_in = K_REQUEST;
      default:     kind_in = K_NOP;
    endcase
  end

  assign rem_step = mod_step(rem, hsh[IP_W-1 -: 8]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = BUCKET_POW2 ? F_PUSH : F_HASH;
        end
      end
      F_HASH: begin
        if (cnt == 2'd3) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = (state == F_IDLE) && !clearing;
    q_push   = (state == F_PUSH) && !q_full;
  end

  assign accept   = s_tvalid && s_tready;
  assign q_task   = cur;
  assign q_bucket = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture and bucket index, one byte per cycle when not a power of two
  always_ff @(posedge clk) begin
    if (accept) begin
      cur.kind <= kind_in;
      cur.ip   <= ip_in;
      cur.mac  <= sender_mac;
      hsh      <= ip_in;
      cnt      <= 2'd0;
      if (BUCKET_POW2) begin
        rem <= BW'(ip_in & IP_W'(BUCKETS - 1));
      end else begin
        rem <= '0;
      end
    end else if (state == F_HASH) begin
      rem <= rem_step;
      hsh <= hsh << 8;
      cnt <= cnt + 2'd1;
    end
  end

  `CHK_SAME(a_hash_only_odd, state == F_HASH, !BUCKET_POW2, "hash pass with power-of-two buckets")

endmodule

`default_nettype wire

// File: rtl/arpc_queue.sv
`default_nettype none

`include "assert_macros.svh"

module arpc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = arpc_pkg::QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  wdata,
  output logic             full,
  input  wire              pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import arpc_pkg::*;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  `CHK_SAME(a_no_overflow, push, !full, "push into full queue")
  `CHK_SAME(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

// File: rtl/arpc_back.sv
`default_nettype none

`include "assert_macros.svh"

module arpc_back #(
  parameter int BUCKETS = arpc_pkg::DEF_BUCKETS,
  parameter int WAYS    = arpc_pkg::DEF_WAYS,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        q_valid,
  input  arpc_pkg::task_t            q_task,
  input  wire [BW-1:0]               q_bucket,
  output logic                       q_pop,
  input  wire [arpc_pkg::IP_W-1:0]   own_ip,
  input  wire [arpc_pkg::MAC_W-1:0]  own_mac,
  output logic                       clearing,
  output logic                       res_valid,
  output arpc_pkg::result_t          res,
  input  wire                        res_ready
);
  import arpc_pkg::*;

  localparam int VW = (WAYS > 1) ? $clog2(WAYS) : 1;

  back_state_t state, state_next;

  // bucket memories: per-way valid bits with victim pointer, and the entries
  logic [VW+WAYS-1:0]     meta_mem [BUCKETS];
  entry_t [WAYS-1:0]      data_mem [BUCKETS];

  logic [VW+WAYS-1:0]     meta_rd;
  entry_t [WAYS-1:0]      data_rd;
  task_t                  cur;
  logic [BW-1:0]          cur_bucket;
  logic [BW-1:0]          clr_cnt;

  logic [WAYS-1:0]        valid_rd;
  logic [VW-1:0]          victim_rd;
  logic                   hit_any;
  logic [VW-1:0]          hit_idx;
  logic                   free_any;
  logic [VW-1:0]          free_idx;
  logic [VW-1:0]          slot;
  logic [VW-1:0]          victim_next;
  logic                   learn;
  logic                   mem_we;
  logic [VW+WAYS-1:0]     meta_wr;
  entry_t [WAYS-1:0]      data_wr;
  result_t                res_next;

  assign valid_rd  = meta_rd[WAYS-1:0];
  assign victim_rd = meta_rd[VW+WAYS-1:WAYS];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: begin
        if (clr_cnt == BW'(BUCKETS - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_pop) begin
          state_next = B_EXEC;
        end
      end
      B_EXEC:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    clearing = (state == B_CLEAR);
    q_pop    = (state == B_IDLE) && q_valid && (!res_valid || res_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // matching way, first free way, lowest index wins
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_rd[w] && (data_rd[w].ip == cur.ip)) begin
        hit_any = 1'b1;
        hit_idx = VW'(w);
      end
      if (!valid_rd[w]) begin
        free_any = 1'b1;
        free_idx = VW'(w);
      end
    end
  end

  // learning: update in place, else free way, else round-robin victim
  always_comb begin
    learn       = (cur.kind == K_LEARN) || (cur.kind == K_REPLY);
    mem_we      = (state == B_EXEC) && learn;
    victim_next = victim_rd;
    if (hit_any) begin
      slot = hit_idx;
    end else if (free_any) begin
      slot = free_idx;
    end else begin
      slot        = victim_rd;
      victim_next = (victim_rd == VW'(WAYS - 1)) ? '0 : victim_rd + 1'b1;
    end
    meta_wr          = {victim_next, valid_rd | (WAYS'(1) << slot)};
    data_wr          = data_rd;
    data_wr[slot].ip  = cur.ip;
    data_wr[slot].mac = cur.mac;
  end

  // result of the request
  always_comb begin
    res_next = '0;
    case (cur.kind)
      K_SHORT: res_next.status = ST_SHORT;
      K_PROTO: res_next.status = ST_PROTO;
      K_REPLY: begin
        res_next.tx_valid      = 1'b1;
        res_next.tx_dest_mac   = cur.mac;
        res_next.tx_opcode     = TX_OP_REP;
        res_next.tx_sender_mac = own_mac;
        res_next.tx_sender_ip  = own_ip;
        res_next.tx_target_mac = cur.mac;
        res_next.tx_target_ip  = cur.ip;
      end
      K_REQUEST: begin
        res_next.tx_valid      = 1'b1;
        res_next.tx_dest_mac   = BCAST_MAC;
        res_next.tx_opcode     = TX_OP_REQ;
        res_next.tx_sender_mac = own_mac;
        res_next.tx_sender_ip  = own_ip;
        res_next.tx_target_ip  = cur.ip;
      end
      K_LOOKUP: begin
        res_next.lookup_hit = hit_any;
        res_next.lookup_mac = hit_any ? data_rd[hit_idx].mac : '0;
      end
      default: res_next = '0;
    endcase
  end

  // bucket read on pop, request captured alongside
  always_ff @(posedge clk) begin
    if (q_pop) begin
      meta_rd    <= meta_mem[q_bucket];
      data_rd    <= data_mem[q_bucket];
      cur        <= q_task;
      cur_bucket <= q_bucket;
    end
  end

  // metadata write: clearing pass after reset, then write-back
  always_ff @(posedge clk) begin
    if (state == B_CLEAR) begin
      meta_mem[clr_cnt] <= '0;
    end else if (mem_we) begin
      meta_mem[cur_bucket] <= meta_wr;
    end
  end

  // entry write-back
  always_ff @(posedge clk) begin
    if (mem_we) begin
      data_mem[cur_bucket] <= data_wr;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == B_EXEC) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_EXEC) begin
      res <= res_next;
    end
  end

  `CHK_SAME(a_exec_slot_free, state == B_EXEC, !res_valid, "result slot busy in execute")
  `CHK_NEXT(a_exec_loads_out, state == B_EXEC, res_valid, "execute left no result")

endmodule

`default_nettype wire
